@@ src/fcc_pkg.sv @@
package fcc_pkg;

  localparam int unsigned MAX_RECORD_BYTES = 65536;
  localparam int unsigned HEADER_BYTES     = 16;

  localparam int unsigned CNT_W  = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CRC_W  = 32;
  localparam int unsigned MAGIC_W = 32;
  localparam int unsigned VER_W  = 16;
  localparam int unsigned PLEN_W = 16;
  localparam int unsigned POFF_W = 5;
  localparam int unsigned CFG_W  = 32;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_VERSION = 2'd2,
    ST_DAMAGED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FLD_MAGIC   = 2'd0,
    FLD_VERSION = 2'd1,
    FLD_LENGTH  = 2'd2,
    FLD_CRC     = 2'd3
  } field_e;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             magic_ok;
    logic [VER_W-1:0] version;
    logic [LEN_W-1:0] length;
    logic [CRC_W-1:0] crc_hdr;
    logic [CRC_W-1:0] crc_run;
  } rec_t;

  function automatic logic [CRC_W-1:0] crc32_byte(logic [CRC_W-1:0] crc, logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ src/fcc_in_if.sv @@
interface fcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

@@ src/fcc_out_if.sv @@
interface fcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fcc_pkg::PLEN_W-1:0]  payload_length;
  logic [fcc_pkg::POFF_W-1:0]  payload_offset;

  modport source (output valid, output status, output payload_length, output payload_offset,
                  input ready);
  modport sink   (input valid, input status, input payload_length, input payload_offset,
                  output ready);
endinterface

@@ src/fcc_track.sv @@
module fcc_track (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         is_final_i,
  input  logic [fcc_pkg::MAGIC_W-1:0]  expected_magic_i,
  output fcc_pkg::rec_t                rec_o
);

  logic [fcc_pkg::CNT_W-1:0] count_q, count_d;
  logic                      magic_ok_q, magic_ok_d;
  logic [fcc_pkg::VER_W-1:0] version_q, version_d;
  logic [fcc_pkg::LEN_W-1:0] length_q, length_d;
  logic [fcc_pkg::CRC_W-1:0] crc_hdr_q, crc_hdr_d;
  logic [fcc_pkg::CRC_W-1:0] crc_run_q, crc_run_d;

  fcc_pkg::rec_t             rec;
  logic [fcc_pkg::CNT_W-1:0] idx;
  logic [fcc_pkg::CNT_W-1:0] pay_idx;

  assign idx     = count_q;
  assign pay_idx = idx - fcc_pkg::CNT_W'(fcc_pkg::HEADER_BYTES);

  always_comb begin
    rec.count    = count_q;
    rec.magic_ok = magic_ok_q;
    rec.version  = version_q;
    rec.length   = length_q;
    rec.crc_hdr  = crc_hdr_q;
    rec.crc_run  = crc_run_q;
    if (step_i && (idx < fcc_pkg::CNT_W'(fcc_pkg::MAX_RECORD_BYTES))) begin
      if (idx < fcc_pkg::CNT_W'(fcc_pkg::HEADER_BYTES)) begin
        case (fcc_pkg::field_e'(idx[3:2]))
          fcc_pkg::FLD_MAGIC: begin
            if (expected_magic_i[8*idx[1:0] +: 8] != data_byte_i) begin
              rec.magic_ok = 1'b0;
            end
          end
          fcc_pkg::FLD_VERSION: begin
            if (!idx[1]) begin
              rec.version[8*idx[0] +: 8] = data_byte_i;
            end
          end
          fcc_pkg::FLD_LENGTH: begin
            rec.length[8*idx[1:0] +: 8] = data_byte_i;
          end
          fcc_pkg::FLD_CRC: begin
            rec.crc_hdr[8*idx[1:0] +: 8] = data_byte_i;
          end
          default: begin
          end
        endcase
      end else if (fcc_pkg::LEN_W'(pay_idx) < length_q) begin
        rec.crc_run = fcc_pkg::crc32_byte(crc_run_q, data_byte_i);
      end
      rec.count = idx + fcc_pkg::CNT_W'(1);
    end
  end

  assign rec_o = rec;

  always_comb begin
    count_d    = rec.count;
    magic_ok_d = rec.magic_ok;
    version_d  = rec.version;
    length_d   = rec.length;
    crc_hdr_d  = rec.crc_hdr;
    crc_run_d  = rec.crc_run;
    if (step_i && is_final_i) begin
      count_d    = '0;
      magic_ok_d = 1'b1;
      version_d  = '0;
      length_d   = '0;
      crc_hdr_d  = '0;
      crc_run_d  = fcc_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      magic_ok_q <= 1'b1;
      version_q  <= '0;
      length_q   <= '0;
      crc_hdr_q  <= '0;
      crc_run_q  <= fcc_pkg::CRC_INIT;
    end else begin
      count_q    <= count_d;
      magic_ok_q <= magic_ok_d;
      version_q  <= version_d;
      length_q   <= length_d;
      crc_hdr_q  <= crc_hdr_d;
      crc_run_q  <= crc_run_d;
    end
  end

endmodule

@@ src/fcc_verdict.sv @@
module fcc_verdict (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         take_i,
  input  logic [fcc_pkg::VER_W-1:0]    expected_version_i,
  input  fcc_pkg::rec_t                rec_i,
  output logic                         valid_o,
  output logic [1:0]                   status_o,
  output logic [fcc_pkg::PLEN_W-1:0]   payload_length_o,
  output logic [fcc_pkg::POFF_W-1:0]   payload_offset_o
);

  logic                        valid_q, valid_d;
  fcc_pkg::status_e            status_q, status_d;
  logic [fcc_pkg::PLEN_W-1:0]  plen_q, plen_d;
  logic [fcc_pkg::POFF_W-1:0]  poff_q, poff_d;
  logic [fcc_pkg::CNT_W-1:0]   present;

  assign present = rec_i.count - fcc_pkg::CNT_W'(fcc_pkg::HEADER_BYTES);

  always_comb begin
    plen_d = '0;
    poff_d = '0;
    if ((rec_i.count < fcc_pkg::CNT_W'(fcc_pkg::HEADER_BYTES)) || !rec_i.magic_ok) begin
      status_d = fcc_pkg::ST_EMPTY;
    end else if (rec_i.version != expected_version_i) begin
      status_d = fcc_pkg::ST_VERSION;
    end else if (rec_i.length > fcc_pkg::LEN_W'(present)) begin
      status_d = fcc_pkg::ST_DAMAGED;
    end else if (~rec_i.crc_run != rec_i.crc_hdr) begin
      status_d = fcc_pkg::ST_DAMAGED;
    end else begin
      status_d = fcc_pkg::ST_OK;
      plen_d   = rec_i.length[fcc_pkg::PLEN_W-1:0];
      poff_d   = fcc_pkg::POFF_W'(fcc_pkg::HEADER_BYTES);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_d;
      plen_q   <= plen_d;
      poff_q   <= poff_d;
    end
  end

  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign payload_length_o = plen_q;
  assign payload_offset_o = poff_q;

endmodule

@@ src/crc_framed_blob_checker.sv @@
// Checks a stored record that arrives one byte per request on in_i, with
// is_final set on its last byte. Each record yields exactly one result
// request on out_o, carrying the status, and the payload length and offset
// when the record is good; bytes that are not final yield nothing.
// A byte is taken into an input register and, as it leaves that register,
// updates the record state (byte count, header fields, running CRC-32). On
// the final byte the verdict is formed in that same cycle and loaded into the
// output register, so a result reaches out_o through the input register and
// then the output register. The sustained rate is one byte per cycle, set by
// the single eight-bit CRC step per cycle, while no final byte waits in the
// input register. When the receiver stalls, the finished result waits in the
// output register while non-final bytes keep flowing; only a second final
// byte holds in the input register, and then in_i.ready drops. The config
// registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write them only while no record is in flight, which the block does not
// enforce. Reset clears the record state, sets the expected magic to zero and
// the expected version to one, and empties both registers of the request path.
module crc_framed_blob_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fcc_in_if.sink                      in_i,
  fcc_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [fcc_pkg::CFG_W-1:0]   cfg_wdata_i
);

  logic [fcc_pkg::MAGIC_W-1:0] magic_q;
  logic [fcc_pkg::VER_W-1:0]   version_q;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;
  logic       in_accept;
  logic       out_free;
  logic       go;

  fcc_pkg::rec_t rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= fcc_pkg::VER_W'(1);
    end else if (cfg_we_i) begin
      case (fcc_pkg::reg_idx_e'(cfg_idx_i))
        fcc_pkg::REG_MAGIC: begin
          magic_q <= cfg_wdata_i[fcc_pkg::MAGIC_W-1:0];
        end
        fcc_pkg::REG_VERSION: begin
          version_q <= cfg_wdata_i[fcc_pkg::VER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free  = !out_o.valid || out_o.ready;
  assign go        = s1_valid_q && (!s1_final_q || out_free);
  assign in_i.ready = !s1_valid_q || go;
  assign in_accept = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= in_i.data_byte;
      s1_final_q <= in_i.is_final;
    end
  end

  fcc_track u_track (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (go),
    .data_byte_i      (s1_byte_q),
    .is_final_i       (s1_final_q),
    .expected_magic_i (magic_q),
    .rec_o            (rec)
  );

  fcc_verdict u_verdict (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (go && s1_final_q),
    .take_i             (out_o.ready),
    .expected_version_i (version_q),
    .rec_i              (rec),
    .valid_o            (out_o.valid),
    .status_o           (out_o.status),
    .payload_length_o   (out_o.payload_length),
    .payload_offset_o   (out_o.payload_offset)
  );

endmodule
